[src/fctg_pkg.sv]
// ----------------------------------------------------------------------------
// fctg_pkg
// Shared types, constants and helpers of the floor cast texel generator.
// ----------------------------------------------------------------------------
package fctg_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int FX_W       = 32;            // Q16.16 words
   localparam int COL_W      = 11;
   localparam int TEX_W      = 10;
   localparam int SHADE_W    = 8;
   localparam int ROW_W      = 11;
   localparam int SCR_W      = 12;
   localparam int SKIP_W     = 5;
   localparam int TSH_W      = 4;
   localparam int PROD_W     = 64;
   localparam int MFX_W      = PROD_W - FRAC_BITS;
   localparam int DVD_W      = 48;
   localparam int DVS_W      = 36;
   localparam int DCNT_W     = 6;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 12;

   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PIXEL_SKIP    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TILE_SHIFT    = 3'd3;

   localparam logic [SCR_W-1:0]  RST_SCREEN_WIDTH  = 12'd640;
   localparam logic [SCR_W-1:0]  RST_SCREEN_HEIGHT = 12'd480;
   localparam logic [SKIP_W-1:0] RST_PIXEL_SKIP    = 5'd1;
   localparam logic [TSH_W-1:0]  RST_TILE_SHIFT    = 4'd6;

   // shade = 2550 * 2^F / (2R + 5 * 2^F)
   localparam logic [DVD_W-1:0]  SHADE_NUM  = DVD_W'(64'd2550 << FRAC_BITS);
   localparam logic [DVS_W-1:0]  SHADE_BIAS = DVS_W'(64'd5 << FRAC_BITS);
   localparam logic [SHADE_W-1:0] SHADE_MAX = 8'd255;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_RWAIT,
      ST_MUL,
      ST_MULW,
      ST_SXWAIT,
      ST_SYSTART,
      ST_SYWAIT,
      ST_SHSTART,
      ST_SHWAIT,
      ST_EMIT
   } fctg_state_type;

   typedef enum logic [1:0] {
      DIV_ROW,
      DIV_STEP_X,
      DIV_STEP_Y,
      DIV_SHADE
   } fctg_div_sel_type;

   typedef struct packed {
      logic             load;        // latch a start-row word
      logic             pix;         // emit current texel, then advance
      logic             horizon_chk; // settle horizon flag of the row
      logic             div_start;
      logic             div_store;
      fctg_div_sel_type div_sel;
      logic             mul_issue;
      logic             mul_store;
      logic [1:0]       mul_idx;
   } fctg_cmd_type;

   typedef struct packed {
      logic p_zero;
      logic div_done;
      logic out_free;
   } fctg_status_type;

   // Texel of one world coordinate: fraction toward zero, scaled by the tile.
   function automatic logic [TEX_W-1:0] texel_of(input logic [FX_W-1:0] w,
                                                 input logic [TSH_W-1:0] ts);
      logic [FX_W-1:0]      mag;
      logic [30:0]          shl;
      logic [14:0]          t;
      logic [15:0]          tmask;
      mag   = w[FX_W-1] ? (~w + 1'b1) : w;
      shl   = {15'd0, mag[FRAC_BITS-1:0]} << ts;
      t     = shl[30:FRAC_BITS];
      if (w[FX_W-1]) begin
         t = ~t + 1'b1;
      end
      tmask = (16'd1 << ts) - 16'd1;
      return t[TEX_W-1:0] & tmask[TEX_W-1:0];
   endfunction

endpackage

[src/fctg_if.sv]
// ----------------------------------------------------------------------------
// fctg_req_if / fctg_rsp_if
// Valid/ready channels of the floor cast texel generator.
// ----------------------------------------------------------------------------
interface fctg_req_if;
   logic        valid;
   logic        ready;
   logic        cmd;
   logic [10:0] row_index;
   logic signed [31:0] dir_x;
   logic signed [31:0] dir_y;
   logic signed [31:0] cam_plane_x;
   logic signed [31:0] cam_plane_y;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;

   modport source (output valid, cmd, row_index, dir_x, dir_y, cam_plane_x,
                   cam_plane_y, pos_x, pos_y, input ready);
   modport sink   (input valid, cmd, row_index, dir_x, dir_y, cam_plane_x,
                   cam_plane_y, pos_x, pos_y, output ready);
endinterface

interface fctg_rsp_if;
   logic       valid;
   logic       ready;
   logic [9:0] texel_x;
   logic [9:0] texel_y;
   logic [10:0] column;
   logic [7:0] brightness;
   logic       horizon;

   modport source (output valid, texel_x, texel_y, column, brightness, horizon,
                   input ready);
   modport sink   (input valid, texel_x, texel_y, column, brightness, horizon,
                   output ready);
endinterface

[src/fctg_div.sv]
// ----------------------------------------------------------------------------
// fctg_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fctg_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [fctg_pkg::DVD_W-1:0]   dividend,
   input  logic [fctg_pkg::DVS_W-1:0]   divisor,
   output logic                         done,
   output logic [fctg_pkg::DVD_W-1:0]   quotient
);
   logic [fctg_pkg::DVS_W-1:0]  rem_ff, rem_in;
   logic [fctg_pkg::DVD_W-1:0]  quo_ff, quo_in;
   logic [fctg_pkg::DVS_W-1:0]  dvs_ff, dvs_in;
   logic [fctg_pkg::DCNT_W-1:0] cnt_ff, cnt_in;
   logic                        done_ff, done_in;
   logic [fctg_pkg::DVS_W:0]    trial;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[fctg_pkg::DVD_W-1]};
      if (start) begin
         rem_in = '0;
         quo_in = dividend;
         dvs_in = divisor;
         cnt_in = fctg_pkg::DCNT_W'(fctg_pkg::DVD_W);
      end else if (cnt_ff != '0) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = fctg_pkg::DVS_W'(trial - {1'b0, dvs_ff});
            quo_in = {quo_ff[fctg_pkg::DVD_W-2:0], 1'b1};
         end else begin
            rem_in = trial[fctg_pkg::DVS_W-1:0];
            quo_in = {quo_ff[fctg_pkg::DVD_W-2:0], 1'b0};
         end
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == fctg_pkg::DCNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

[src/fctg_datapath.sv]
// ----------------------------------------------------------------------------
// fctg_datapath
// Row setup arithmetic, per-pixel stepping, settings and result register.
// ----------------------------------------------------------------------------
module fctg_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  fctg_pkg::fctg_cmd_type            cmd,
   output fctg_pkg::fctg_status_type         status,
   input  logic                              csr_we,
   input  logic [fctg_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [fctg_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic [fctg_pkg::ROW_W-1:0]        in_row_index,
   input  logic signed [fctg_pkg::FX_W-1:0]  in_dir_x,
   input  logic signed [fctg_pkg::FX_W-1:0]  in_dir_y,
   input  logic signed [fctg_pkg::FX_W-1:0]  in_plane_x,
   input  logic signed [fctg_pkg::FX_W-1:0]  in_plane_y,
   input  logic signed [fctg_pkg::FX_W-1:0]  in_pos_x,
   input  logic signed [fctg_pkg::FX_W-1:0]  in_pos_y,
   input  logic                              out_ready,
   output logic                              out_valid,
   output logic [fctg_pkg::TEX_W-1:0]        out_texel_x,
   output logic [fctg_pkg::TEX_W-1:0]        out_texel_y,
   output logic [fctg_pkg::COL_W-1:0]        out_column,
   output logic [fctg_pkg::SHADE_W-1:0]      out_brightness,
   output logic                              out_horizon
);
   localparam int W  = fctg_pkg::FX_W;
   localparam int MW = fctg_pkg::MFX_W;

   // settings
   logic [fctg_pkg::SCR_W-1:0]  sw_ff, sw_in, sh_ff, sh_in;
   logic [fctg_pkg::SKIP_W-1:0] skip_ff, skip_in;
   logic [fctg_pkg::TSH_W-1:0]  ts_ff, ts_in;

   // latched start-row word
   logic [fctg_pkg::ROW_W-1:0] row_ff, row_in;
   logic signed [W-1:0] dx_ff, dx_in, dy_ff, dy_in, plx_ff, plx_in, ply_ff, ply_in;
   logic signed [W-1:0] psx_ff, psx_in, psy_ff, psy_in;

   // row state
   logic [W-1:0] wx_ff, wx_in, wy_ff, wy_in, stx_ff, stx_in, sty_ff, sty_in;
   logic [fctg_pkg::COL_W-1:0]   col_ff, col_in;
   logic [fctg_pkg::SHADE_W-1:0] shade_ff, shade_in;
   logic                         hor_ff, hor_in;

   // setup intermediates
   logic signed [W-1:0]                 r_ff, r_in;
   logic signed [MW-1:0]                mx_ff, mx_in, my_ff, my_in;
   logic signed [fctg_pkg::PROD_W-1:0]  prod_ff, prod_in;

   // result register
   logic                         ov_ff, ov_in;
   logic [fctg_pkg::TEX_W-1:0]   otx_ff, otx_in, oty_ff, oty_in;
   logic [fctg_pkg::COL_W-1:0]   ocol_ff, ocol_in;
   logic [fctg_pkg::SHADE_W-1:0] osh_ff, osh_in;
   logic                         ohor_ff, ohor_in;

   // combinational helpers
   logic signed [12:0]          p;
   logic [12:0]                 p_mag;
   logic [12:0]                 two_p;
   logic signed [W:0]           dif_x, dif_y;
   logic signed [W-1:0]         sat_x, sat_y, mul_b;
   logic [fctg_pkg::PROD_W-1:0] fx_sum;
   logic signed [MW-1:0]        fx;
   logic [MW-1:0]               mx_mag, my_mag;
   logic [fctg_pkg::SCR_W-1:0]  sw_eff;
   logic signed [fctg_pkg::DVS_W-1:0] den;
   logic                        den_pos;
   logic [fctg_pkg::DVD_W-1:0]  dvd, quo, quo_neg;
   logic [fctg_pkg::DVS_W-1:0]  dvs;
   logic                        div_done;
   logic [W-1:0]                adv_x, adv_y;

   fctg_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.div_start),
      .dividend(dvd),
      .divisor (dvs),
      .done    (div_done),
      .quotient(quo)
   );

   always_comb begin
      p     = $signed({2'b00, row_ff}) - $signed({2'b00, sh_ff[fctg_pkg::SCR_W-1:1]});
      p_mag = p[12] ? 13'(-p) : 13'(p);
      two_p = {p_mag[11:0], 1'b0};
      dif_x = $signed({dx_ff[W-1], dx_ff}) - $signed({plx_ff[W-1], plx_ff});
      dif_y = $signed({dy_ff[W-1], dy_ff}) - $signed({ply_ff[W-1], ply_ff});
      sat_x = (dif_x[W] != dif_x[W-1]) ? {dif_x[W], {(W-1){~dif_x[W]}}} : dif_x[W-1:0];
      sat_y = (dif_y[W] != dif_y[W-1]) ? {dif_y[W], {(W-1){~dif_y[W]}}} : dif_y[W-1:0];
      case (cmd.mul_idx)
         2'd0:    mul_b = plx_ff;
         2'd1:    mul_b = ply_ff;
         2'd2:    mul_b = sat_x;
         default: mul_b = sat_y;
      endcase
      // truncate toward zero on the way down to Q32.16
      fx_sum = prod_ff + {{(fctg_pkg::PROD_W-fctg_pkg::FRAC_BITS){1'b0}},
                          {fctg_pkg::FRAC_BITS{prod_ff[fctg_pkg::PROD_W-1]}}};
      fx     = fx_sum[fctg_pkg::PROD_W-1:fctg_pkg::FRAC_BITS];
      mx_mag = mx_ff[MW-1] ? MW'(-mx_ff) : MW'(mx_ff);
      my_mag = my_ff[MW-1] ? MW'(-my_ff) : MW'(my_ff);
      sw_eff = (sw_ff == '0) ? fctg_pkg::SCR_W'(1) : sw_ff;
      den     = $signed({{(fctg_pkg::DVS_W-W-1){r_ff[W-1]}}, r_ff, 1'b0})
              + $signed(fctg_pkg::SHADE_BIAS);
      den_pos = !den[fctg_pkg::DVS_W-1] && (den != '0);
      case (cmd.div_sel)
         fctg_pkg::DIV_ROW: begin
            dvd = fctg_pkg::DVD_W'({sh_ff, {fctg_pkg::FRAC_BITS{1'b0}}});
            dvs = fctg_pkg::DVS_W'(two_p);
         end
         fctg_pkg::DIV_STEP_X: begin
            dvd = fctg_pkg::DVD_W'({mx_mag, 1'b0});
            dvs = fctg_pkg::DVS_W'(sw_eff);
         end
         fctg_pkg::DIV_STEP_Y: begin
            dvd = fctg_pkg::DVD_W'({my_mag, 1'b0});
            dvs = fctg_pkg::DVS_W'(sw_eff);
         end
         default: begin
            dvd = fctg_pkg::SHADE_NUM;
            dvs = den;
         end
      endcase
      quo_neg = ~quo + 1'b1;
      adv_x   = W'(stx_ff * {{(W-fctg_pkg::SKIP_W){1'b0}}, skip_ff});
      adv_y   = W'(sty_ff * {{(W-fctg_pkg::SKIP_W){1'b0}}, skip_ff});
   end

   always_comb begin
      sw_in = sw_ff; sh_in = sh_ff; skip_in = skip_ff; ts_in = ts_ff;
      row_in = row_ff; dx_in = dx_ff; dy_in = dy_ff; plx_in = plx_ff; ply_in = ply_ff;
      psx_in = psx_ff; psy_in = psy_ff;
      wx_in = wx_ff; wy_in = wy_ff; stx_in = stx_ff; sty_in = sty_ff;
      col_in = col_ff; shade_in = shade_ff; hor_in = hor_ff;
      r_in = r_ff; mx_in = mx_ff; my_in = my_ff; prod_in = prod_ff;
      ov_in = ov_ff && !out_ready;
      otx_in = otx_ff; oty_in = oty_ff; ocol_in = ocol_ff; osh_in = osh_ff; ohor_in = ohor_ff;

      if (csr_we) begin
         case (csr_index)
            fctg_pkg::CSR_SCREEN_WIDTH:  sw_in   = csr_wdata;
            fctg_pkg::CSR_SCREEN_HEIGHT: sh_in   = csr_wdata;
            fctg_pkg::CSR_PIXEL_SKIP:    skip_in = csr_wdata[fctg_pkg::SKIP_W-1:0];
            fctg_pkg::CSR_TILE_SHIFT:    ts_in   = csr_wdata[fctg_pkg::TSH_W-1:0];
            default: ;
         endcase
      end

      if (cmd.load) begin
         row_in = in_row_index;
         dx_in  = in_dir_x;   dy_in  = in_dir_y;
         plx_in = in_plane_x; ply_in = in_plane_y;
         psx_in = in_pos_x;   psy_in = in_pos_y;
         col_in = '0;
      end

      if (cmd.horizon_chk) begin
         hor_in = (p == '0);
         if (p == '0) begin
            shade_in = '0;
            wx_in = '0; wy_in = '0; stx_in = '0; sty_in = '0;
         end
      end

      if (cmd.mul_issue) begin
         prod_in = fctg_pkg::PROD_W'(r_ff) * fctg_pkg::PROD_W'(mul_b);
      end

      if (cmd.mul_store) begin
         case (cmd.mul_idx)
            2'd0:    mx_in = fx;
            2'd1:    my_in = fx;
            2'd2:    wx_in = psx_ff + fx[W-1:0];
            default: wy_in = psy_ff + fx[W-1:0];
         endcase
      end

      if (cmd.div_store) begin
         case (cmd.div_sel)
            fctg_pkg::DIV_ROW: begin
               if (p[12]) begin
                  r_in = (quo > fctg_pkg::DVD_W'(64'h8000_0000)) ?
                         {1'b1, {(W-1){1'b0}}} : quo_neg[W-1:0];
               end else begin
                  r_in = (quo > fctg_pkg::DVD_W'(64'h7FFF_FFFF)) ?
                         {1'b0, {(W-1){1'b1}}} : quo[W-1:0];
               end
            end
            fctg_pkg::DIV_STEP_X: stx_in = mx_ff[MW-1] ? quo_neg[W-1:0] : quo[W-1:0];
            fctg_pkg::DIV_STEP_Y: sty_in = my_ff[MW-1] ? quo_neg[W-1:0] : quo[W-1:0];
            default: begin
               if (!den_pos) begin
                  shade_in = '0;
               end else if (quo > fctg_pkg::DVD_W'(fctg_pkg::SHADE_MAX)) begin
                  shade_in = fctg_pkg::SHADE_MAX;
               end else begin
                  shade_in = quo[fctg_pkg::SHADE_W-1:0];
               end
            end
         endcase
      end

      if (cmd.pix) begin
         ov_in   = 1'b1;
         otx_in  = hor_ff ? '0 : fctg_pkg::texel_of(wx_ff, ts_ff);
         oty_in  = hor_ff ? '0 : fctg_pkg::texel_of(wy_ff, ts_ff);
         ocol_in = col_ff;
         osh_in  = shade_ff;
         ohor_in = hor_ff;
         wx_in   = wx_ff + adv_x;
         wy_in   = wy_ff + adv_y;
         col_in  = col_ff + fctg_pkg::COL_W'(skip_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sw_ff <= fctg_pkg::RST_SCREEN_WIDTH;
         sh_ff <= fctg_pkg::RST_SCREEN_HEIGHT;
         skip_ff <= fctg_pkg::RST_PIXEL_SKIP;
         ts_ff <= fctg_pkg::RST_TILE_SHIFT;
         wx_ff <= '0; wy_ff <= '0; stx_ff <= '0; sty_ff <= '0;
         col_ff <= '0; shade_ff <= '0; hor_ff <= 1'b0;
         ov_ff <= 1'b0;
      end else begin
         sw_ff <= sw_in; sh_ff <= sh_in; skip_ff <= skip_in; ts_ff <= ts_in;
         wx_ff <= wx_in; wy_ff <= wy_in; stx_ff <= stx_in; sty_ff <= sty_in;
         col_ff <= col_in; shade_ff <= shade_in; hor_ff <= hor_in;
         ov_ff <= ov_in;
      end
      row_ff <= row_in; dx_ff <= dx_in; dy_ff <= dy_in; plx_ff <= plx_in;
      ply_ff <= ply_in; psx_ff <= psx_in; psy_ff <= psy_in;
      r_ff <= r_in; mx_ff <= mx_in; my_ff <= my_in; prod_ff <= prod_in;
      otx_ff <= otx_in; oty_ff <= oty_in; ocol_ff <= ocol_in;
      osh_ff <= osh_in; ohor_ff <= ohor_in;
   end

   assign status.p_zero   = (p == '0);
   assign status.div_done = div_done;
   assign status.out_free = !ov_ff || out_ready;

   assign out_valid      = ov_ff;
   assign out_texel_x    = otx_ff;
   assign out_texel_y    = oty_ff;
   assign out_column     = ocol_ff;
   assign out_brightness = osh_ff;
   assign out_horizon    = ohor_ff;
endmodule

[src/fctg_ctrl.sv]
// ----------------------------------------------------------------------------
// fctg_ctrl
// Sequencer: accepts words and steps the datapath through row setup.
// ----------------------------------------------------------------------------
module fctg_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   input  logic                       in_cmd,
   output logic                       in_ready,
   input  fctg_pkg::fctg_status_type  status,
   output fctg_pkg::fctg_cmd_type     cmd
);
   fctg_pkg::fctg_state_type state_ff, state_in;
   logic [1:0]               idx_ff, idx_in;
   logic                     accept;

   assign in_ready = (state_ff == fctg_pkg::ST_IDLE) && status.out_free;
   assign accept   = in_valid && in_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      case (state_ff)
         fctg_pkg::ST_IDLE:   if (accept && !in_cmd) state_in = fctg_pkg::ST_CHECK;
         fctg_pkg::ST_CHECK:  state_in = status.p_zero ? fctg_pkg::ST_EMIT
                                                       : fctg_pkg::ST_RWAIT;
         fctg_pkg::ST_RWAIT: begin
            if (status.div_done) begin
               state_in = fctg_pkg::ST_MUL;
               idx_in   = '0;
            end
         end
         fctg_pkg::ST_MUL:    state_in = fctg_pkg::ST_MULW;
         fctg_pkg::ST_MULW: begin
            idx_in   = idx_ff + 1'b1;
            state_in = (idx_ff == 2'd3) ? fctg_pkg::ST_SXWAIT : fctg_pkg::ST_MUL;
         end
         fctg_pkg::ST_SXWAIT: if (status.div_done) state_in = fctg_pkg::ST_SYSTART;
         fctg_pkg::ST_SYSTART: state_in = fctg_pkg::ST_SYWAIT;
         fctg_pkg::ST_SYWAIT: if (status.div_done) state_in = fctg_pkg::ST_SHSTART;
         fctg_pkg::ST_SHSTART: state_in = fctg_pkg::ST_SHWAIT;
         fctg_pkg::ST_SHWAIT: if (status.div_done) state_in = fctg_pkg::ST_EMIT;
         fctg_pkg::ST_EMIT:   if (status.out_free) state_in = fctg_pkg::ST_IDLE;
         default:             state_in = fctg_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd         = '0;
      cmd.mul_idx = idx_ff;
      cmd.div_sel = fctg_pkg::DIV_ROW;
      case (state_ff)
         fctg_pkg::ST_IDLE: begin
            cmd.load = accept && !in_cmd;
            cmd.pix  = accept && in_cmd;
         end
         fctg_pkg::ST_CHECK: begin
            cmd.horizon_chk = 1'b1;
            cmd.div_start   = !status.p_zero;
         end
         fctg_pkg::ST_RWAIT:  cmd.div_store = status.div_done;
         fctg_pkg::ST_MUL:    cmd.mul_issue = 1'b1;
         fctg_pkg::ST_MULW: begin
            cmd.mul_store = 1'b1;
            if (idx_ff == 2'd3) begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = fctg_pkg::DIV_STEP_X;
            end
         end
         fctg_pkg::ST_SXWAIT: begin
            cmd.div_store = status.div_done;
            cmd.div_sel   = fctg_pkg::DIV_STEP_X;
         end
         fctg_pkg::ST_SYSTART: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = fctg_pkg::DIV_STEP_Y;
         end
         fctg_pkg::ST_SYWAIT: begin
            cmd.div_store = status.div_done;
            cmd.div_sel   = fctg_pkg::DIV_STEP_Y;
         end
         fctg_pkg::ST_SHSTART: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = fctg_pkg::DIV_SHADE;
         end
         fctg_pkg::ST_SHWAIT: begin
            cmd.div_store = status.div_done;
            cmd.div_sel   = fctg_pkg::DIV_SHADE;
         end
         fctg_pkg::ST_EMIT:   cmd.pix = status.out_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fctg_pkg::ST_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end
endmodule

[src/floor_cast_texel_generator.sv]
// Next-pixel word: result registered the cycle after accept; one word per cycle
// while the result side keeps up. Start-row word: set up by four passes
// through the shared one-bit-per-cycle divider and four multiplier passes;
// a horizon row skips both. Synchronous active-high reset clears the row
// state and result valid and loads the settings defaults.
// ----------------------------------------------------------------------------
// floor_cast_texel_generator
// Floor texel coordinates for a raycaster, one screen row at a time.
// ----------------------------------------------------------------------------
module floor_cast_texel_generator (
   input  logic                            clock,
   input  logic                            reset,
   fctg_req_if.sink                        req_ch,
   fctg_rsp_if.source                      rsp_ch,
   input  logic                            csr_we,
   input  logic [fctg_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [fctg_pkg::CSR_DATA_W-1:0] csr_wdata
);
   fctg_pkg::fctg_cmd_type    cmd;
   fctg_pkg::fctg_status_type status;
   logic                      ready;

   // sequencer: holds in setup states until the row is ready, then emits column 0
   fctg_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .in_valid(req_ch.valid),
      .in_cmd  (req_ch.cmd),
      .in_ready(ready),
      .status  (status),
      .cmd     (cmd)
   );

   assign req_ch.ready = ready;

   // datapath: divider, multiplier, stepping adders and the result register
   fctg_datapath u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .in_row_index  (req_ch.row_index),
      .in_dir_x      (req_ch.dir_x),
      .in_dir_y      (req_ch.dir_y),
      .in_plane_x    (req_ch.cam_plane_x),
      .in_plane_y    (req_ch.cam_plane_y),
      .in_pos_x      (req_ch.pos_x),
      .in_pos_y      (req_ch.pos_y),
      .out_ready     (rsp_ch.ready),
      .out_valid     (rsp_ch.valid),
      .out_texel_x   (rsp_ch.texel_x),
      .out_texel_y   (rsp_ch.texel_y),
      .out_column    (rsp_ch.column),
      .out_brightness(rsp_ch.brightness),
      .out_horizon   (rsp_ch.horizon)
   );
endmodule

[src/fctg_checker.sv]
// ----------------------------------------------------------------------------
// fctg_checker
// Port-level checks of the floor cast texel generator.
// ----------------------------------------------------------------------------
module fctg_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [9:0] rsp_texel_x,
   input logic [9:0] rsp_texel_y,
   input logic [7:0] rsp_brightness,
   input logic       rsp_horizon
);
   // hold a stalled result word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word dropped while stalled");

   // horizon rows carry no texel and no shade
   a_horizon: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_horizon |-> rsp_texel_x == '0 && rsp_texel_y == '0
                                   && rsp_brightness == '0)
      else $error("horizon word with nonzero texel or shade");

   // no word accepted while a stalled result blocks the slot
   a_no_accept_blocked: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("input accepted while result slot is blocked");

   // result valid does not rise right out of reset
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(reset))
      else $error("result word right out of reset");

   // result valid is known after each accepted word
   a_req_known: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !(rsp_valid === 1'bx))
      else $error("result valid unknown after accept");
endmodule

bind floor_cast_texel_generator fctg_checker u_fctg_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_ch.valid),
   .req_ready     (req_ch.ready),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_texel_x   (rsp_ch.texel_x),
   .rsp_texel_y   (rsp_ch.texel_y),
   .rsp_brightness(rsp_ch.brightness),
   .rsp_horizon   (rsp_ch.horizon)
);

[test/fctg_checker.sv]
// ----------------------------------------------------------------------------
// fctg_scoreboard
// Predicts the floor texel of every accepted request word and compares it,
// field by field, with the result words in arrival order.
// ----------------------------------------------------------------------------
module fctg_scoreboard (
   input  logic                            clock,
   input  logic                            reset,
   fctg_req_if                             req_ch,
   fctg_rsp_if                             rsp_ch,
   input  logic                            csr_we,
   input  logic [fctg_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [fctg_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                              fail_count,
   output int                              texels_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [fctg_pkg::TEX_W-1:0]   tx;
      logic [fctg_pkg::TEX_W-1:0]   ty;
      logic [fctg_pkg::COL_W-1:0]   col;
      logic [fctg_pkg::SHADE_W-1:0] shade;
      logic                         hor;
   } texel_word_type;

   texel_word_type texel_queue[$];

   logic [fctg_pkg::SCR_W-1:0]  width_q, height_q;
   logic [fctg_pkg::SKIP_W-1:0] skip_q;
   logic [fctg_pkg::TSH_W-1:0]  tshift_q;
   logic signed [31:0]          wx, wy, sx, sy;
   logic [fctg_pkg::COL_W-1:0]  col_q;
   logic [7:0]                  shade_q;
   logic                        hor_q;

   assign texels_pending = texel_queue.size();

   function automatic longint sat_word(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // trunc(a*b / 2^F) toward zero
   function automatic longint fx_mul(input longint a, input longint b);
      longint prod, mag;
      prod = a * b;
      mag  = (prod < 0) ? -prod : prod;
      mag  = mag >>> fctg_pkg::FRAC_BITS;
      return (prod < 0) ? -mag : mag;
   endfunction

   function automatic logic [fctg_pkg::TEX_W-1:0] tile_texel(input logic signed [31:0] w);
      longint v, mag, fr, t, tmask;
      v     = w;
      mag   = (v < 0) ? -v : v;
      fr    = mag & ((64'sd1 << fctg_pkg::FRAC_BITS) - 1);
      t     = (fr << tshift_q) >>> fctg_pkg::FRAC_BITS;
      tmask = (64'sd1 << tshift_q) - 1;
      if (v < 0) t = -t;
      return fctg_pkg::TEX_W'(t & tmask & 64'h3FF);
   endfunction

   task automatic predict_texel(input logic c, input logic [10:0] row,
                                input logic signed [31:0] dx, dy, cpx, cpy, px, py);
      longint p, r, sw, den, q;
      texel_word_type e;
      if (!c) begin
         p = longint'(row) - longint'(height_q / 2);
         col_q = '0;
         if (p == 0) begin
            hor_q = 1'b1; shade_q = '0;
            wx = 0; wy = 0; sx = 0; sy = 0;
         end else begin
            hor_q = 1'b0;
            r  = sat_word((longint'(height_q) << fctg_pkg::FRAC_BITS) / (2 * p));
            sw = (width_q != 0) ? longint'(width_q) : 1;
            sx = 32'(fx_mul(r, cpx) * 2 / sw);
            sy = 32'(fx_mul(r, cpy) * 2 / sw);
            wx = 32'(longint'(px) + fx_mul(r, sat_word(longint'(dx) - longint'(cpx))));
            wy = 32'(longint'(py) + fx_mul(r, sat_word(longint'(dy) - longint'(cpy))));
            den = 2 * r + (64'sd5 << fctg_pkg::FRAC_BITS);
            if (den <= 0) shade_q = '0;
            else begin
               q = (64'sd2550 << fctg_pkg::FRAC_BITS) / den;
               shade_q = (q > 255) ? 8'd255 : 8'(q);
            end
         end
      end
      e.tx    = hor_q ? '0 : tile_texel(wx);
      e.ty    = hor_q ? '0 : tile_texel(wy);
      e.col   = col_q;
      e.shade = shade_q;
      e.hor   = hor_q;
      texel_queue.push_back(e);
      // advance by step times skip
      wx    = wx + 32'(longint'(sx) * longint'(skip_q));
      wy    = wy + 32'(longint'(sy) * longint'(skip_q));
      col_q = col_q + fctg_pkg::COL_W'(skip_q);
   endtask

   always @(posedge clock) begin
      texel_word_type e, a;
      if (reset) begin
         width_q  <= fctg_pkg::RST_SCREEN_WIDTH;
         height_q <= fctg_pkg::RST_SCREEN_HEIGHT;
         skip_q   <= fctg_pkg::RST_PIXEL_SKIP;
         tshift_q <= fctg_pkg::RST_TILE_SHIFT;
         wx = 0; wy = 0; sx = 0; sy = 0;
         col_q = '0; shade_q = '0; hor_q = 1'b0;
         texel_queue.delete();
         fail_count <= 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               fctg_pkg::CSR_SCREEN_WIDTH:  width_q  <= csr_wdata;
               fctg_pkg::CSR_SCREEN_HEIGHT: height_q <= csr_wdata;
               fctg_pkg::CSR_PIXEL_SKIP:    skip_q   <= fctg_pkg::SKIP_W'(csr_wdata);
               fctg_pkg::CSR_TILE_SHIFT:    tshift_q <= fctg_pkg::TSH_W'(csr_wdata);
               default: ;
            endcase
         end
         if (req_ch.valid && req_ch.ready)
            predict_texel(req_ch.cmd, req_ch.row_index, req_ch.dir_x, req_ch.dir_y,
                          req_ch.cam_plane_x, req_ch.cam_plane_y,
                          req_ch.pos_x, req_ch.pos_y);
         if (rsp_ch.valid && rsp_ch.ready) begin
            a = {rsp_ch.texel_x, rsp_ch.texel_y, rsp_ch.column,
                 rsp_ch.brightness, rsp_ch.horizon};
            if (texel_queue.size() == 0) begin
               if (fail_count < 10)
                  $display("unexpected texel word %h", a);
               fail_count <= fail_count + 1;
            end else begin
               e = texel_queue.pop_front();
               if (e !== a) begin
                  if (fail_count < 10)
                     $display({"texel mismatch: exp tx=%0d ty=%0d col=%0d sh=%0d hor=%0d,",
                               " got tx=%0d ty=%0d col=%0d sh=%0d hor=%0d"},
                              e.tx, e.ty, e.col, e.shade, e.hor,
                              a.tx, a.ty, a.col, a.shade, a.hor);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

[test/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Drives row starts and pixel steps into the floor texel generator under
// several screen settings, with random gaps and result stalls.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 20000;
   // register index past the end of the list, written to check it is ignored
   localparam logic [fctg_pkg::CSR_IDX_W-1:0] CSR_UNUSED = 3'd7;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [fctg_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [fctg_pkg::CSR_DATA_W-1:0] csr_wdata = '0;
   int fail_count, texels_pending;
   int idle_cycles = 0;

   fctg_req_if req_ch();
   fctg_rsp_if rsp_ch();

   floor_cast_texel_generator uut (
      .clock, .reset, .req_ch(req_ch.sink), .rsp_ch(rsp_ch.source),
      .csr_we, .csr_index, .csr_wdata
   );

   fctg_scoreboard chk (
      .clock, .reset, .req_ch, .rsp_ch, .csr_we, .csr_index, .csr_wdata,
      .fail_count, .texels_pending
   );

   always #5 clock = ~clock;

   // Initialize request side to known values.
   initial begin
      req_ch.valid = 1'b0; req_ch.cmd = 1'b1; req_ch.row_index = '0;
      req_ch.dir_x = '0; req_ch.dir_y = '0; req_ch.cam_plane_x = '0;
      req_ch.cam_plane_y = '0; req_ch.pos_x = '0; req_ch.pos_y = '0;
      rsp_ch.ready = 1'b0;
   end

   // Result side: stall a random number of cycles before each word.
   initial begin : result_sink
      int gap;
      @(posedge clock);
      forever begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
         if (gap > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
      end
   end

   // Watchdog: count cycles without any handshake.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   function automatic logic signed [31:0] rand_fx();
      case ($urandom_range(0, 3))
         0: return $urandom();
         1: return 32'($signed($urandom_range(0, 32'h3FFFF)) - 32'sh20000);
         2: return $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
         default: return 32'($signed($urandom_range(0, 32'hFFFF)) - 32'sh8000);
      endcase
   endfunction

   // Send one word; hold valid until accepted and leave it high for the caller.
   task automatic send_word(input logic c, input logic [10:0] row,
                            input logic signed [31:0] dx, dy, cpx, cpy, px, py,
                            input bit gaps);
      int gap;
      gap = (gaps && $urandom_range(0, 2) != 0) ? $urandom_range(0, 16) : 0;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.cmd <= c; req_ch.row_index <= row;
      req_ch.dir_x <= dx; req_ch.dir_y <= dy;
      req_ch.cam_plane_x <= cpx; req_ch.cam_plane_y <= cpy;
      req_ch.pos_x <= px; req_ch.pos_y <= py;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic release_valid();
      req_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   // Drain every expected word, then hold for the horizon/row latency.
   task automatic drain();
      release_valid();
      while (texels_pending != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   // Drive one register write; the caller drops the write enable afterwards.
   task automatic write_csr(input logic [fctg_pkg::CSR_IDX_W-1:0] idx,
                            input logic [fctg_pkg::CSR_DATA_W-1:0] val);
      csr_we <= 1'b1; csr_index <= idx; csr_wdata <= val;
      @(posedge clock);
   endtask

   task automatic random_row(input bit gaps, input int height);
      int n;
      logic [10:0] row;
      case ($urandom_range(0, 5))
         0:       row = 11'(height / 2);
         1:       row = 11'($urandom());
         default: row = 11'($urandom_range(0, height > 0 ? height - 1 : 0));
      endcase
      send_word(1'b0, row, rand_fx(), rand_fx(), rand_fx(), rand_fx(),
                rand_fx(), rand_fx(), gaps);
      n = $urandom_range(0, 12);
      repeat (n) send_word(1'b1, 11'($urandom()), $urandom(), $urandom(), $urandom(),
                           $urandom(), $urandom(), $urandom(), gaps);
   endtask

   initial begin : stimulus
      int words;
      int heights[4] = '{480, 2, 2047, 100};
      int widths[4]  = '{640, 1, 0, 2048};
      int skips[4]   = '{1, 16, 0, 31};
      int shifts[4]  = '{6, 0, 10, 15};
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: next pixel before any row, horizon, extremes.
      send_word(1'b1, '0, '0, '0, '0, '0, '0, '0, 1'b0);
      send_word(1'b0, 11'd240, '1, '1, '1, '1, '1, '1, 1'b0);
      send_word(1'b1, '0, '0, '0, '0, '0, '0, '0, 1'b0);
      send_word(1'b0, 11'd2047, 32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000,
                32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000, 1'b0);
      send_word(1'b1, '1, '0, '0, '0, '0, '0, '0, 1'b0);
      send_word(1'b0, 11'd0, 32'sh10000, 32'sh0, 32'sh0, 32'shA8F5,
                -32'sh18000, 32'sh28000, 1'b0);
      send_word(1'b1, '0, '0, '0, '0, '0, '0, '0, 1'b0);
      send_word(1'b0, 11'd239, 32'sh10000, 32'sh0, 32'sh0, 32'shA8F5,
                32'sh58000, 32'sh38000, 1'b0);
      repeat (4) send_word(1'b1, '0, '0, '0, '0, '0, '0, '0, 1'b0);
      send_word(1'b0, 11'd479, 32'sh0, -32'sh10000, -32'shA8F5, 32'sh0,
                32'sh12345, -32'sh54321, 1'b0);
      send_word(1'b1, '0, '0, '0, '0, '0, '0, '0, 1'b0);
      drain();

      // Random phases, one per setting, extremes included.
      for (int ph = 0; ph < 4; ph++) begin
         write_csr(fctg_pkg::CSR_SCREEN_WIDTH, fctg_pkg::CSR_DATA_W'(widths[ph]));
         write_csr(fctg_pkg::CSR_SCREEN_HEIGHT, fctg_pkg::CSR_DATA_W'(heights[ph]));
         write_csr(fctg_pkg::CSR_PIXEL_SKIP, fctg_pkg::CSR_DATA_W'(skips[ph]));
         write_csr(fctg_pkg::CSR_TILE_SHIFT, fctg_pkg::CSR_DATA_W'(shifts[ph]));
         write_csr(CSR_UNUSED, 12'hFFF);
         csr_we <= 1'b0;
         words = 0;
         while (words < 110) begin
            random_row(($urandom_range(0, 3) != 0), heights[ph]);
            words = words + 7;
         end
         // pause until every expected word has come back
         drain();
      end

      while (texels_pending != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule
